### rtl/crl_pkg.sv
// Shared types and constants of the color line rasterizer.
package crl_pkg;

  localparam int CH_W   = 8;
  localparam int PIX_W  = 6;
  localparam int CFG_W  = 7;
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  typedef enum logic [0:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [PIX_W-1:0] x;
    logic [PIX_W-1:0] y;
    logic [CH_W-1:0]  r;
    logic [CH_W-1:0]  g;
    logic [CH_W-1:0]  b;
    logic             last;
  } pix_t;

endpackage

### rtl/crl_queue.sv
// Two-entry word queue used between front and back and on the result side.
module crl_queue import crl_pkg::*; #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  logic [W-1:0] mem [2];
  logic         wp_r, rp_r;
  logic [1:0]   cnt_r;
  logic         do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= ~wp_r;
      if (do_pop)  rp_r <= ~rp_r;
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

### rtl/crl_front.sv
// Front end: takes an edge, classifies it and divides out the color steps.
module crl_front import crl_pkg::*; #(
  parameter int COORD_BITS      = 10,
  parameter int COLOR_FRAC_BITS = 16,
  parameter int DESC_W = 5*COORD_BITS + 34 + 3*(CH_W + COLOR_FRAC_BITS)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_push,
  output logic                         in_full,
  input  logic signed [COORD_BITS-1:0] in_x_start,
  input  logic signed [COORD_BITS-1:0] in_y_start,
  input  logic signed [COORD_BITS-1:0] in_x_end,
  input  logic signed [COORD_BITS-1:0] in_y_end,
  input  logic [CH_W-1:0]              in_red_start,
  input  logic [CH_W-1:0]              in_green_start,
  input  logic [CH_W-1:0]              in_blue_start,
  input  logic [CH_W-1:0]              in_red_end,
  input  logic [CH_W-1:0]              in_green_end,
  input  logic [CH_W-1:0]              in_blue_end,
  output logic                         dq_push,
  output logic [DESC_W-1:0]            dq_wdata,
  input  logic                         dq_full
);

  localparam int CB = COORD_BITS;
  localparam int DW = CB + 1;
  localparam int EW = CB + 3;
  localparam int QW = CH_W + COLOR_FRAC_BITS;
  localparam int CW = $clog2(QW + 1);

  typedef enum logic [1:0] {S_IDLE, S_SETUP, S_DIV, S_PUSH} state_t;

  state_t state_r;
  logic signed [CB-1:0] xs_r, ys_r, xe_r, ye_r;
  logic [CH_W-1:0]      c0_r [3];
  logic [CH_W-1:0]      c1_r [3];

  logic          ymaj_r, neg_maj_r, neg_min_r, tie_r;
  logic [CB-1:0] major_r, minor_r;
  logic [CB-1:0] pm_r, pn_r;
  logic [EW-1:0] e0_r;
  logic [2:0]    up_r;
  logic [QW-1:0] qd_r  [3];
  logic [CB-1:0] rem_r [3];
  logic [CW-1:0] cnt_r;

  // edge classification
  logic signed [DW-1:0] dx, dy;
  logic [DW-1:0]        adx, ady;
  logic                 ymaj, dx_pos, dy_pos, dx_neg, dy_neg;
  logic [CB-1:0]        major, minor;
  logic [CH_W-1:0]      diff [3];

  always_comb begin
    dx     = {xe_r[CB-1], xe_r} - {xs_r[CB-1], xs_r};
    dy     = {ye_r[CB-1], ye_r} - {ys_r[CB-1], ys_r};
    dx_neg = dx[DW-1];
    dy_neg = dy[DW-1];
    dx_pos = !dx_neg && (dx != '0);
    dy_pos = !dy_neg && (dy != '0);
    adx    = dx_neg ? -dx : dx;
    ady    = dy_neg ? -dy : dy;
    ymaj   = ady > adx;
    major  = ymaj ? ady[CB-1:0] : adx[CB-1:0];
    minor  = ymaj ? adx[CB-1:0] : ady[CB-1:0];
    for (int c = 0; c < 3; c++) begin
      diff[c] = (c0_r[c] < c1_r[c]) ? c1_r[c] - c0_r[c] : c0_r[c] - c1_r[c];
    end
  end

  // restoring divider step, one quotient bit per channel a cycle
  logic [CB:0]   trial [3];
  logic          qbit  [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      trial[c] = {rem_r[c], qd_r[c][QW-1]};
      qbit[c]  = trial[c] >= {1'b0, major_r};
    end
  end

  assign in_full = (state_r != S_IDLE);
  assign dq_push = (state_r == S_PUSH);
  assign dq_wdata = {ymaj_r, neg_maj_r, neg_min_r, tie_r, major_r, minor_r, pm_r, pn_r,
                     e0_r, up_r, c0_r[0], c0_r[1], c0_r[2], qd_r[0], qd_r[1], qd_r[2]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_push) begin
            xs_r    <= in_x_start;
            ys_r    <= in_y_start;
            xe_r    <= in_x_end;
            ye_r    <= in_y_end;
            c0_r[0] <= in_red_start;
            c0_r[1] <= in_green_start;
            c0_r[2] <= in_blue_start;
            c1_r[0] <= in_red_end;
            c1_r[1] <= in_green_end;
            c1_r[2] <= in_blue_end;
            state_r <= S_SETUP;
          end
        end
        S_SETUP: begin
          ymaj_r    <= ymaj;
          neg_maj_r <= ymaj ? dy_neg : dx_neg;
          neg_min_r <= ymaj ? dx_neg : dy_neg;
          tie_r     <= dx_pos && dy_pos && ymaj || dx_neg && dy_pos && !ymaj ||
                       dx_pos && dy_neg && !ymaj || dx_neg && dy_neg && ymaj;
          major_r   <= major;
          minor_r   <= minor;
          pm_r      <= ymaj ? ys_r : xs_r;
          pn_r      <= ymaj ? xs_r : ys_r;
          e0_r      <= {2'b00, minor, 1'b0} - {3'b000, major};
          for (int c = 0; c < 3; c++) begin
            up_r[c]  <= c0_r[c] < c1_r[c];
            qd_r[c]  <= {diff[c], {COLOR_FRAC_BITS{1'b0}}};
            rem_r[c] <= '0;
          end
          cnt_r   <= CW'(QW);
          // drop degenerate edges
          state_r <= (major == '0) ? S_IDLE : S_DIV;
        end
        S_DIV: begin
          for (int c = 0; c < 3; c++) begin
            rem_r[c] <= qbit[c] ? CB'(trial[c] - {1'b0, major_r}) : trial[c][CB-1:0];
            qd_r[c]  <= {qd_r[c][QW-2:0], qbit[c]};
          end
          cnt_r <= cnt_r - CW'(1);
          if (cnt_r == CW'(1)) state_r <= S_PUSH;
        end
        S_PUSH: begin
          if (!dq_full) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/crl_walk.sv
// Back end: walks the edge, interpolates color and emits visible pixels.
module crl_walk import crl_pkg::*; #(
  parameter int TILE_SIZE       = 64,
  parameter int COORD_BITS      = 10,
  parameter int COLOR_FRAC_BITS = 16,
  parameter int DESC_W = 5*COORD_BITS + 34 + 3*(CH_W + COLOR_FRAC_BITS)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [CFG_W-1:0]   width_in_use,
  input  logic [CFG_W-1:0]   height_in_use,
  input  logic               dq_empty,
  input  logic [DESC_W-1:0]  dq_rdata,
  output logic               dq_pop,
  output logic               oq_push,
  output pix_t               oq_wdata,
  input  logic               oq_full
);

  localparam int CB = COORD_BITS;
  localparam int EW = CB + 3;
  localparam int F  = COLOR_FRAC_BITS;
  localparam int QW = CH_W + F;
  localparam logic [CFG_W-1:0] TILE_C = CFG_W'(TILE_SIZE);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_FLUSH} state_t;

  // descriptor fields
  logic          d_ymaj, d_neg_maj, d_neg_min, d_tie;
  logic [CB-1:0] d_major, d_minor, d_pm, d_pn;
  logic [EW-1:0] d_e0;
  logic [2:0]    d_up;
  logic [CH_W-1:0] d_c0 [3];
  logic [QW-1:0]   d_step [3];

  assign {d_ymaj, d_neg_maj, d_neg_min, d_tie, d_major, d_minor, d_pm, d_pn, d_e0, d_up,
          d_c0[0], d_c0[1], d_c0[2], d_step[0], d_step[1], d_step[2]} = dq_rdata;

  state_t        state_r;
  logic          ymaj_r, neg_maj_r, neg_min_r, tie_r;
  logic [CB-1:0] major_r, minor_r, pm_r, pn_r, cnt_r;
  logic signed [EW-1:0] e_r;
  logic [2:0]    up_r;
  logic [QW-1:0] acc_r  [3];
  logic [QW-1:0] step_r [3];
  logic          pend_v_r;
  pix_t          pend_r;

  logic [CFG_W-1:0] wv, hv;
  logic [CB-1:0]    px, py;
  logic             vis, advance, minor_step;
  logic signed [EW-1:0] e_nxt;
  pix_t             cur;

  always_comb begin
    wv  = (width_in_use > TILE_C) ? TILE_C : width_in_use;
    hv  = (height_in_use > TILE_C) ? TILE_C : height_in_use;
    px  = ymaj_r ? pn_r : pm_r;
    py  = ymaj_r ? pm_r : pn_r;
    vis = !px[CB-1] && !py[CB-1] && (px < CB'(wv)) && (py < CB'(hv));
    // hold the walk while a visible pixel cannot release the one before it
    advance = !(vis && pend_v_r && oq_full);
    minor_step = (e_r > 0) || (tie_r && (e_r == '0));
    e_nxt = e_r + $signed({2'b00, minor_r, 1'b0})
          - (minor_step ? $signed({2'b00, major_r, 1'b0}) : $signed(EW'(0)));
    cur.x    = px[PIX_W-1:0];
    cur.y    = py[PIX_W-1:0];
    cur.r    = acc_r[0][QW-1:F];
    cur.g    = acc_r[1][QW-1:F];
    cur.b    = acc_r[2][QW-1:F];
    cur.last = 1'b0;
  end

  assign dq_pop = (state_r == S_IDLE) && !dq_empty;

  always_comb begin
    oq_wdata = pend_r;
    oq_push  = 1'b0;
    if (state_r == S_RUN) begin
      oq_wdata.last = 1'b0;
      oq_push       = advance && vis && pend_v_r;
    end else if (state_r == S_FLUSH) begin
      oq_wdata.last = 1'b1;
      oq_push       = pend_v_r && !oq_full;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      pend_v_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (!dq_empty) begin
            ymaj_r    <= d_ymaj;
            neg_maj_r <= d_neg_maj;
            neg_min_r <= d_neg_min;
            tie_r     <= d_tie;
            major_r   <= d_major;
            minor_r   <= d_minor;
            pm_r      <= d_pm;
            pn_r      <= d_pn;
            cnt_r     <= d_major;
            e_r       <= d_e0;
            up_r      <= d_up;
            for (int c = 0; c < 3; c++) begin
              acc_r[c]  <= {d_c0[c], {F{1'b0}}};
              step_r[c] <= d_step[c];
            end
            state_r <= S_RUN;
          end
        end
        S_RUN: begin
          if (advance) begin
            if (vis) begin
              pend_r   <= cur;
              pend_v_r <= 1'b1;
            end
            for (int c = 0; c < 3; c++) begin
              if (up_r[c])                    acc_r[c] <= acc_r[c] + step_r[c];
              else if (acc_r[c] >= step_r[c]) acc_r[c] <= acc_r[c] - step_r[c];
              else                            acc_r[c] <= '0;
            end
            if (minor_step) pn_r <= neg_min_r ? pn_r - CB'(1) : pn_r + CB'(1);
            pm_r <= neg_maj_r ? pm_r - CB'(1) : pm_r + CB'(1);
            e_r  <= e_nxt;
            cnt_r <= cnt_r - CB'(1);
            if (cnt_r == '0) state_r <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          if (!pend_v_r) begin
            state_r <= S_IDLE;
          end else if (!oq_full) begin
            pend_v_r <= 1'b0;
            state_r  <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/color_interpolated_line_raster_core.sv
// Top level: config registers, front end, descriptor queue, walker, result queue.
// An edge passes through front-end setup, the divide, the descriptor push, the walker load,
// the walk steps and the release of the last pixel to the result queue.
// The front end can take a new edge while the walker is still walking the last one;
// a full result queue holds the walker.
// Synchronous reset empties both queues and sets width_in_use and height_in_use to 64.
module color_interpolated_line_raster_core import crl_pkg::*; #(
  parameter int TILE_SIZE       = 64,
  parameter int COORD_BITS      = 10,
  parameter int COLOR_FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_push,
  output logic                         in_full,
  input  logic signed [COORD_BITS-1:0] in_x_start,
  input  logic signed [COORD_BITS-1:0] in_y_start,
  input  logic signed [COORD_BITS-1:0] in_x_end,
  input  logic signed [COORD_BITS-1:0] in_y_end,
  input  logic [CH_W-1:0]              in_red_start,
  input  logic [CH_W-1:0]              in_green_start,
  input  logic [CH_W-1:0]              in_blue_start,
  input  logic [CH_W-1:0]              in_red_end,
  input  logic [CH_W-1:0]              in_green_end,
  input  logic [CH_W-1:0]              in_blue_end,
  output logic                         out_empty,
  input  logic                         out_pop,
  output logic [PIX_W-1:0]             out_pixel_x,
  output logic [PIX_W-1:0]             out_pixel_y,
  output logic [CH_W-1:0]              out_red,
  output logic [CH_W-1:0]              out_green,
  output logic [CH_W-1:0]              out_blue,
  output logic                         out_last_pixel,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [APB_AW-1:0]            paddr,
  input  logic [APB_DW-1:0]            pwdata,
  output logic [APB_DW-1:0]            prdata,
  output logic                         pready
);

  localparam int DESC_W = 5*COORD_BITS + 34 + 3*(CH_W + COLOR_FRAC_BITS);

  logic [CFG_W-1:0] width_r, height_r;
  cfg_reg_t         reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = cfg_reg_t'(paddr[2]);

  always_comb begin
    case (reg_sel)
      REG_WIDTH:  prdata = APB_DW'(width_r);
      REG_HEIGHT: prdata = APB_DW'(height_r);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= CFG_W'(64);
      height_r <= CFG_W'(64);
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        REG_WIDTH:  width_r  <= pwdata[CFG_W-1:0];
        REG_HEIGHT: height_r <= pwdata[CFG_W-1:0];
        default:    width_r  <= width_r;
      endcase
    end
  end

  logic              dq_push, dq_full, dq_pop, dq_empty;
  logic [DESC_W-1:0] dq_wdata, dq_rdata;
  logic              oq_push, oq_full;
  pix_t              oq_wdata, oq_rdata;

  crl_front #(
    .COORD_BITS(COORD_BITS), .COLOR_FRAC_BITS(COLOR_FRAC_BITS), .DESC_W(DESC_W)
  ) u_front (
    .clk, .rst_n, .in_push, .in_full,
    .in_x_start, .in_y_start, .in_x_end, .in_y_end,
    .in_red_start, .in_green_start, .in_blue_start,
    .in_red_end, .in_green_end, .in_blue_end,
    .dq_push, .dq_wdata, .dq_full
  );

  crl_queue #(.W(DESC_W)) u_desc_q (
    .clk, .rst_n, .push(dq_push), .wdata(dq_wdata), .full(dq_full),
    .pop(dq_pop), .rdata(dq_rdata), .empty(dq_empty)
  );

  crl_walk #(
    .TILE_SIZE(TILE_SIZE), .COORD_BITS(COORD_BITS),
    .COLOR_FRAC_BITS(COLOR_FRAC_BITS), .DESC_W(DESC_W)
  ) u_walk (
    .clk, .rst_n, .width_in_use(width_r), .height_in_use(height_r),
    .dq_empty, .dq_rdata, .dq_pop, .oq_push, .oq_wdata, .oq_full
  );

  crl_queue #(.W($bits(pix_t))) u_out_q (
    .clk, .rst_n, .push(oq_push), .wdata(oq_wdata), .full(oq_full),
    .pop(out_pop), .rdata(oq_rdata), .empty(out_empty)
  );

  assign out_pixel_x    = oq_rdata.x;
  assign out_pixel_y    = oq_rdata.y;
  assign out_red        = oq_rdata.r;
  assign out_green      = oq_rdata.g;
  assign out_blue       = oq_rdata.b;
  assign out_last_pixel = oq_rdata.last;

endmodule
